### hw/rtl/tdmf_pkg.sv
// Shared constants and controller/datapath interface types for the duplicate filter.
`timescale 1ns / 1ps

package tdmf_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int CATEGORIES_DEF  = 2;
    localparam int USEC_PER_SEC    = 1000000;
    localparam int DEFAULT_MAX_AGE = 10 * USEC_PER_SEC;

    localparam int HASH_W    = 64;
    localparam int TIME_W    = 64;
    localparam int AGE_W     = 32;
    localparam int REMOVED_W = 6;
    localparam int OCC_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE_VIEWER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE_AGENT  = 1'b1;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_PRUNE = 1'b1;

    typedef struct packed {
        logic accept;
        logic add_load;
        logic prune_load;
        logic issue;
        logic write;
        logic dec;
        logic next_cat;
        logic sel_req_cat;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic in_prune;
        logic in_cat_ok;
        logic left_zero;
        logic rd_vld;
        logic hash_hit;
        logic expired;
        logic cat_last;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/timed_duplicate_message_filter.sv
// Top level of the time-windowed two-category duplicate message filter.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  request  | i_in_valid / o_in_ready      | i_req_type i_category i_msg_hash i_now_us
//  result   | o_out_valid / i_out_ready    | o_accepted o_removed_count o_occupancy
//  config   | i_cfg_we (no wait)           | i_cfg_addr i_cfg_wdata
//
// Add of a new hash scans the category's held entries from the newest back, then writes it;
// a duplicate ends the scan at the entry that matches. The single read port of the entry
// RAMs sets the scan pace. Prune sweeps every category from its oldest entry and stops at
// the first entry that is still young, or when none is left.
// One request is in flight at a time; the next is taken once the result is in the output
// register, so a stalled result blocks at most one further request.
// Reset (synchronous, active low) empties all rings at once; entry RAMs are not cleared.
`timescale 1ns / 1ps

module timed_duplicate_message_filter #(
    parameter int ENTRIES    = tdmf_pkg::ENTRIES_DEF,
    parameter int CATEGORIES = tdmf_pkg::CATEGORIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tdmf_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [tdmf_pkg::AGE_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic                            i_category,
    input  logic [tdmf_pkg::HASH_W-1:0]     i_msg_hash,
    input  logic [tdmf_pkg::TIME_W-1:0]     i_now_us,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted,
    output logic [tdmf_pkg::REMOVED_W-1:0]  o_removed_count,
    output logic [tdmf_pkg::OCC_W-1:0]      o_occupancy
);
    import tdmf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tdmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tdmf_dp #(
        .ENTRIES    (ENTRIES),
        .CATEGORIES (CATEGORIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req_type),
        .i_category      (i_category),
        .i_msg_hash      (i_msg_hash),
        .i_now_us        (i_now_us),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_accepted      (o_accepted),
        .o_removed_count (o_removed_count),
        .o_occupancy     (o_occupancy),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

### hw/rtl/tdmf_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module tdmf_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tdmf_ctrl.sv
// Controller state machine: sequences add lookups, prune sweeps and result handoff.
`timescale 1ns / 1ps

module tdmf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tdmf_pkg::t_dp_sts i_sts,
    output tdmf_pkg::t_dp_cmd o_cmd
);
    import tdmf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_LD   = 3'd1;
    localparam logic [2:0] S_ADD_SCAN = 3'd2;
    localparam logic [2:0] S_ADD_WR   = 3'd3;
    localparam logic [2:0] S_PR_LD    = 3'd4;
    localparam logic [2:0] S_PR_SCAN  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;
    logic       young;
    logic       drained;

    assign young      = i_sts.rd_vld && !i_sts.expired;
    assign drained    = i_sts.left_zero && !i_sts.rd_vld;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_sts.in_prune) begin
                        n_state = S_PR_LD;
                    end else if (i_sts.in_cat_ok) begin
                        n_state = S_ADD_LD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ADD_LD: begin
                cmd.add_load = 1'b1;
                n_state      = S_ADD_SCAN;
            end
            S_ADD_SCAN: begin
                if (i_sts.rd_vld && i_sts.hash_hit) begin
                    n_state = S_DONE;
                end else if (drained) begin
                    n_state = S_ADD_WR;
                end else begin
                    cmd.issue = !i_sts.left_zero;
                end
            end
            S_ADD_WR: begin
                cmd.write = 1'b1;
                n_state   = S_DONE;
            end
            S_PR_LD: begin
                cmd.prune_load = 1'b1;
                n_state        = S_PR_SCAN;
            end
            S_PR_SCAN: begin
                cmd.dec = i_sts.rd_vld && i_sts.expired;
                if (young || drained) begin
                    if (i_sts.cat_last) begin
                        cmd.sel_req_cat = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        cmd.next_cat = 1'b1;
                        n_state      = S_PR_LD;
                    end
                end else begin
                    cmd.issue = !i_sts.left_zero;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

### hw/rtl/tdmf_dp.sv
// Datapath: ring pointers, counts, age registers, entry RAMs, compare and result register.
`timescale 1ns / 1ps

module tdmf_dp #(
    parameter int ENTRIES    = tdmf_pkg::ENTRIES_DEF,
    parameter int CATEGORIES = tdmf_pkg::CATEGORIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tdmf_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [tdmf_pkg::AGE_W-1:0]      i_cfg_wdata,
    input  logic                            i_req_type,
    input  logic                            i_category,
    input  logic [tdmf_pkg::HASH_W-1:0]     i_msg_hash,
    input  logic [tdmf_pkg::TIME_W-1:0]     i_now_us,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_accepted,
    output logic [tdmf_pkg::REMOVED_W-1:0]  o_removed_count,
    output logic [tdmf_pkg::OCC_W-1:0]      o_occupancy,
    input  tdmf_pkg::t_dp_cmd               i_cmd,
    output tdmf_pkg::t_dp_sts               o_sts
);
    import tdmf_pkg::*;

    localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW    = $clog2(ENTRIES + 1);
    localparam int CW    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int DEPTH = CATEGORIES * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AGE_W-1:0]     r_max_age0;
    logic [AGE_W-1:0]     r_max_age1;
    logic [SW-1:0]        r_newest [CATEGORIES];
    logic [NW-1:0]        r_count  [CATEGORIES];

    logic                 r_cat;
    logic                 r_cat_ok;
    logic                 r_is_prune;
    logic [HASH_W-1:0]    r_hash;
    logic [TIME_W-1:0]    r_now;
    logic [CW-1:0]        r_cur;
    logic [SW-1:0]        r_slot;
    logic [NW-1:0]        r_left;
    logic                 r_rd_vld;
    logic [REMOVED_W-1:0] r_removed;
    logic                 r_acc;

    logic                 r_out_vld;
    logic                 r_out_acc;
    logic [REMOVED_W-1:0] r_out_removed;
    logic [OCC_W-1:0]     r_out_occ;

    logic [SW-1:0]        cur_newest;
    logic [NW-1:0]        cur_count;
    logic [SW-1:0]        wr_slot;
    logic [SW:0]          oldest_sum;
    logic [SW-1:0]        oldest_slot;
    logic [SW-1:0]        slot_inc;
    logic [SW-1:0]        slot_dec;
    logic [AW-1:0]        cat_base;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [HASH_W-1:0]    hash_rdata;
    logic [TIME_W-1:0]    time_rdata;
    logic [TIME_W-1:0]    age;
    logic [AGE_W-1:0]     cur_max_age;
    logic                 in_cat_ok;
    logic [OCC_W-1:0]     occ_sat;

    assign cur_newest = r_newest[r_cur];
    assign cur_count  = r_count[r_cur];

    assign in_cat_ok = (32'(i_category) < 32'(CATEGORIES));

    assign slot_inc = (r_slot == SW'(ENTRIES - 1)) ? '0 : r_slot + 1'b1;
    assign slot_dec = (r_slot == '0) ? SW'(ENTRIES - 1) : r_slot - 1'b1;
    assign wr_slot  = (cur_newest == SW'(ENTRIES - 1)) ? '0 : cur_newest + 1'b1;

    // oldest = newest - (count - 1) around the ring
    assign oldest_sum  = {1'b0, cur_newest} + (SW + 1)'(ENTRIES)
                       - (SW + 1)'(cur_count - 1'b1);
    assign oldest_slot = (oldest_sum >= (SW + 1)'(ENTRIES))
                       ? SW'(oldest_sum - (SW + 1)'(ENTRIES)) : SW'(oldest_sum);

    assign cat_base = AW'(r_cur) * AW'(ENTRIES);
    assign rd_addr  = cat_base + AW'(r_slot);
    assign wr_addr  = cat_base + AW'(wr_slot);

    always_comb begin
        if (r_cur == CW'(0)) begin
            cur_max_age = r_max_age0;
        end else if (CATEGORIES > 1 && r_cur == CW'(1)) begin
            cur_max_age = r_max_age1;
        end else begin
            cur_max_age = AGE_W'(DEFAULT_MAX_AGE);
        end
    end

    assign age     = r_now - time_rdata;
    assign occ_sat = (cur_count > NW'(31)) ? OCC_W'(31) : OCC_W'(cur_count);

    tdmf_ram #(
        .WIDTH (HASH_W),
        .DEPTH (DEPTH)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (wr_addr),
        .i_wdata (r_hash),
        .i_raddr (rd_addr),
        .o_rdata (hash_rdata)
    );

    tdmf_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (wr_addr),
        .i_wdata (r_now),
        .i_raddr (rd_addr),
        .o_rdata (time_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age0 <= AGE_W'(DEFAULT_MAX_AGE);
            r_max_age1 <= AGE_W'(DEFAULT_MAX_AGE);
            for (int c = 0; c < CATEGORIES; c++) begin
                r_newest[c] <= '0;
                r_count[c]  <= '0;
            end
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_MAX_AGE_VIEWER) begin
                r_max_age0 <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == CFG_MAX_AGE_AGENT && CATEGORIES > 1) begin
                r_max_age1 <= i_cfg_wdata;
            end
            if (i_cmd.write) begin
                r_newest[r_cur] <= wr_slot;
                if (cur_count != NW'(ENTRIES)) begin
                    r_count[r_cur] <= cur_count + 1'b1;
                end
            end else if (i_cmd.dec) begin
                r_count[r_cur] <= cur_count - 1'b1;
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request context and scan pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cat      <= i_category;
            r_cat_ok   <= in_cat_ok;
            r_is_prune <= (i_req_type == REQ_PRUNE);
            r_hash     <= i_msg_hash;
            r_now      <= i_now_us;
            r_removed  <= '0;
            r_acc      <= 1'b0;
            if (i_req_type == REQ_PRUNE || !in_cat_ok) begin
                r_cur <= '0;
            end else begin
                r_cur <= CW'(i_category);
            end
        end
        if (i_cmd.add_load) begin
            r_slot <= cur_newest;
            r_left <= cur_count;
        end else if (i_cmd.prune_load) begin
            r_slot <= oldest_slot;
            r_left <= cur_count;
        end else if (i_cmd.issue) begin
            r_slot <= r_is_prune ? slot_inc : slot_dec;
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.next_cat) begin
            r_cur <= r_cur + 1'b1;
        end else if (i_cmd.sel_req_cat) begin
            r_cur <= r_cat_ok ? CW'(r_cat) : '0;
        end
        if (i_cmd.dec && r_removed != '1) begin
            r_removed <= r_removed + 1'b1;
        end
        if (i_cmd.write) begin
            r_acc <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_acc     <= r_acc;
            r_out_removed <= r_removed;
            r_out_occ     <= r_cat_ok ? occ_sat : '0;
        end
    end

    assign o_sts.in_prune  = (i_req_type == REQ_PRUNE);
    assign o_sts.in_cat_ok = in_cat_ok;
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.rd_vld    = r_rd_vld;
    assign o_sts.hash_hit  = (hash_rdata == r_hash);
    assign o_sts.expired   = (age >= TIME_W'(cur_max_age));
    assign o_sts.cat_last  = (r_cur == CW'(CATEGORIES - 1));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid     = r_out_vld;
    assign o_accepted      = r_out_acc;
    assign o_removed_count = r_out_removed;
    assign o_occupancy     = r_out_occ;

endmodule
